### design/sm83_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sm83 8-bit alu
// no dependencies; used by sm83_core and sm83_alu_8bit

package sm83_pkg;

	// operation codes
	typedef enum logic [4:0] {
		CMD_ADD  = 5'd0,
		CMD_ADC  = 5'd1,
		CMD_SUB  = 5'd2,
		CMD_SBC  = 5'd3,
		CMD_AND  = 5'd4,
		CMD_XOR  = 5'd5,
		CMD_OR   = 5'd6,
		CMD_CP   = 5'd7,
		CMD_INC  = 5'd8,
		CMD_DEC  = 5'd9,
		CMD_DAA  = 5'd10,
		CMD_CPL  = 5'd11,
		CMD_CCF  = 5'd12,
		CMD_SCF  = 5'd13,
		CMD_RLC  = 5'd14,
		CMD_RRC  = 5'd15,
		CMD_RL   = 5'd16,
		CMD_RR   = 5'd17,
		CMD_SLA  = 5'd18,
		CMD_SRA  = 5'd19,
		CMD_SRL  = 5'd20,
		CMD_SWAP = 5'd21,
		CMD_BIT  = 5'd22,
		CMD_RES  = 5'd23,
		CMD_SET  = 5'd24,
		CMD_RLCA = 5'd25,
		CMD_RRCA = 5'd26,
		CMD_RLA  = 5'd27,
		CMD_RRA  = 5'd28
	} cmd_t;

	// decimal adjust constants
	localparam logic [7:0] DAA_LIMIT    = 8'h99;
	localparam logic [7:0] DAA_ADJ_HI   = 8'h60;
	localparam logic [7:0] DAA_ADJ_LO   = 8'h06;
	localparam logic [3:0] DAA_NIB_LIMIT = 4'h9;

	typedef struct packed {
		logic zero;
		logic sub;
		logic half;
		logic carry;
	} flags_t;

	// one operation word
	typedef struct packed {
		logic [4:0] cmd;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [2:0] bit_index;
		flags_t     flags;
	} op_t;

	// one result word
	typedef struct packed {
		logic [7:0] result;
		logic       write_result;
		flags_t     flags;
	} res_t;

endpackage

### design/sm83_core.sv
`timescale 1ns / 1ps
// combinational datapath of the sm83 alu: result byte, write enable and flags
// depends on sm83_pkg

module sm83_core (
	input  sm83_pkg::op_t  op,
	output sm83_pkg::res_t res
);

	always_comb begin
		logic [7:0] a;
		logic [7:0] b;
		logic       t;
		logic [8:0] wide;
		logic [4:0] nib;
		logic [7:0] adj;
		logic [7:0] r;
		logic       wr;
		logic       z;
		logic       n;
		logic       h;
		logic       c;
		logic       zfrom;

		a     = op.operand_a;
		b     = op.operand_b;
		t     = 1'b0;
		wide  = 9'd0;
		nib   = 5'd0;
		adj   = 8'd0;
		r     = a;
		wr    = 1'b1;
		z     = op.flags.zero;
		n     = op.flags.sub;
		h     = op.flags.half;
		c     = op.flags.carry;
		zfrom = 1'b0;

		case (sm83_pkg::cmd_t'(op.cmd))
			sm83_pkg::CMD_ADD, sm83_pkg::CMD_ADC: begin
				t     = (sm83_pkg::cmd_t'(op.cmd) == sm83_pkg::CMD_ADC) ? op.flags.carry : 1'b0;
				wide  = {1'b0, a} + {1'b0, b} + {8'd0, t};
				nib   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
				r     = wide[7:0];
				n     = 1'b0;
				h     = nib[4];
				c     = wide[8];
				zfrom = 1'b1;
			end
			sm83_pkg::CMD_SUB, sm83_pkg::CMD_SBC, sm83_pkg::CMD_CP: begin
				t     = (sm83_pkg::cmd_t'(op.cmd) == sm83_pkg::CMD_SBC) ? op.flags.carry : 1'b0;
				// borrow shows up in the top bit
				wide  = {1'b0, a} - {1'b0, b} - {8'd0, t};
				nib   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
				r     = wide[7:0];
				n     = 1'b1;
				h     = nib[4];
				c     = wide[8];
				zfrom = 1'b1;
				wr    = (sm83_pkg::cmd_t'(op.cmd) != sm83_pkg::CMD_CP);
			end
			sm83_pkg::CMD_AND: begin
				r = a & b; n = 1'b0; h = 1'b1; c = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_XOR: begin
				r = a ^ b; n = 1'b0; h = 1'b0; c = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_OR: begin
				r = a | b; n = 1'b0; h = 1'b0; c = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_INC: begin
				r = a + 8'd1; n = 1'b0; h = (a[3:0] == 4'hF); zfrom = 1'b1;
			end
			sm83_pkg::CMD_DEC: begin
				r = a - 8'd1; n = 1'b1; h = (a[3:0] == 4'h0); zfrom = 1'b1;
			end
			sm83_pkg::CMD_DAA: begin
				if (!op.flags.sub) begin
					if (op.flags.carry || (a > sm83_pkg::DAA_LIMIT)) begin
						adj = adj | sm83_pkg::DAA_ADJ_HI;
						c   = 1'b1;
					end
					if (op.flags.half || (a[3:0] > sm83_pkg::DAA_NIB_LIMIT)) begin
						adj = adj | sm83_pkg::DAA_ADJ_LO;
					end
					r = a + adj;
				end else begin
					if (op.flags.carry) adj = adj | sm83_pkg::DAA_ADJ_HI;
					if (op.flags.half)  adj = adj | sm83_pkg::DAA_ADJ_LO;
					r = a - adj;
				end
				h     = 1'b0;
				zfrom = 1'b1;
			end
			sm83_pkg::CMD_CPL: begin
				r = ~a; n = 1'b1; h = 1'b1;
			end
			sm83_pkg::CMD_CCF: begin
				n = 1'b0; h = 1'b0; c = ~op.flags.carry;
			end
			sm83_pkg::CMD_SCF: begin
				n = 1'b0; h = 1'b0; c = 1'b1;
			end
			sm83_pkg::CMD_RLC: begin
				c = a[7]; r = {a[6:0], a[7]}; n = 1'b0; h = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_RRC: begin
				c = a[0]; r = {a[0], a[7:1]}; n = 1'b0; h = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_RL: begin
				c = a[7]; r = {a[6:0], op.flags.carry}; n = 1'b0; h = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_RR: begin
				c = a[0]; r = {op.flags.carry, a[7:1]}; n = 1'b0; h = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_SLA: begin
				c = a[7]; r = {a[6:0], 1'b0}; n = 1'b0; h = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_SRA: begin
				c = a[0]; r = {a[7], a[7:1]}; n = 1'b0; h = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_SRL: begin
				c = a[0]; r = {1'b0, a[7:1]}; n = 1'b0; h = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_SWAP: begin
				r = {a[3:0], a[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0; zfrom = 1'b1;
			end
			sm83_pkg::CMD_BIT: begin
				wr = 1'b0; n = 1'b0; h = 1'b1; z = ~a[op.bit_index];
			end
			sm83_pkg::CMD_RES: begin
				r = a & ~(8'h01 << op.bit_index);
			end
			sm83_pkg::CMD_SET: begin
				r = a | (8'h01 << op.bit_index);
			end
			// accumulator rotates always clear z
			sm83_pkg::CMD_RLCA: begin
				c = a[7]; r = {a[6:0], a[7]}; n = 1'b0; h = 1'b0; z = 1'b0;
			end
			sm83_pkg::CMD_RRCA: begin
				c = a[0]; r = {a[0], a[7:1]}; n = 1'b0; h = 1'b0; z = 1'b0;
			end
			sm83_pkg::CMD_RLA: begin
				c = a[7]; r = {a[6:0], op.flags.carry}; n = 1'b0; h = 1'b0; z = 1'b0;
			end
			sm83_pkg::CMD_RRA: begin
				c = a[0]; r = {op.flags.carry, a[7:1]}; n = 1'b0; h = 1'b0; z = 1'b0;
			end
			default: begin
				// unused codes: no write, flags unchanged
				r  = a;
				wr = 1'b0;
			end
		endcase

		if (zfrom) z = (r == 8'd0);

		res.result       = r;
		res.write_result = wr;
		res.flags.zero   = z;
		res.flags.sub    = n;
		res.flags.half   = h;
		res.flags.carry  = c;
	end

endmodule

### design/sm83_alu_8bit.sv
`timescale 1ns / 1ps
// top level of the sm83 8-bit alu: input register, datapath, result register
// depends on sm83_pkg and sm83_core
//
// usage
//  - input channel: in_valid / in_stall, one operation word per accepted edge
//    (in_valid high, in_stall low); fields cmd, operand_a, operand_b,
//    bit_index and the four incoming flags
//  - output channel: out_valid / out_stall, one result word per operation:
//    result byte, write_result and the four new flags
//  - path: an accepted operation word is held in the input register, then its
//    result word in the result register, which drives out_valid; the alu
//    logic sits between the two
//  - throughput: one word per cycle, sustained, as long as the receiver takes
//    results; the only limit is the two-entry register pipeline
//  - back pressure: when out_stall holds, the result register keeps its word
//    and the input register still takes one more word; only when both are
//    full does in_stall rise, so no word is dropped or repeated
//  - reset (arst_n low, asynchronous) empties both stages; payload registers
//    are not cleared and carry no meaning until their valid bit is set
//  - no configuration, no internal state beyond the two pipeline stages

module sm83_alu_8bit (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_stall,
	input  logic [4:0] cmd,
	input  logic [7:0] operand_a,
	input  logic [7:0] operand_b,
	input  logic [2:0] bit_index,
	input  logic       zero_in,
	input  logic       sub_in,
	input  logic       half_in,
	input  logic       carry_in,

	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] result,
	output logic       write_result,
	output logic       zero_out,
	output logic       sub_out,
	output logic       half_out,
	output logic       carry_out
);

	// stage 1: registered operation word
	logic           valid_s1;
	sm83_pkg::op_t  op_s1;
	// stage 2: registered result word
	logic           valid_s2;
	sm83_pkg::res_t res_s2;

	sm83_pkg::res_t res_comb;
	logic           adv_s1;

	// stage 1 may move on when the result register is empty or being taken
	assign adv_s1   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;

	sm83_core u_core (
		.op  (op_s1),
		.res (res_comb)
	);

	// control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (adv_s1)    valid_s2 <= valid_s1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1.cmd         <= cmd;
			op_s1.operand_a   <= operand_a;
			op_s1.operand_b   <= operand_b;
			op_s1.bit_index   <= bit_index;
			op_s1.flags.zero  <= zero_in;
			op_s1.flags.sub   <= sub_in;
			op_s1.flags.half  <= half_in;
			op_s1.flags.carry <= carry_in;
		end
		if (adv_s1 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid    = valid_s2;
	assign result       = res_s2.result;
	assign write_result = res_s2.write_result;
	assign zero_out     = res_s2.flags.zero;
	assign sub_out      = res_s2.flags.sub;
	assign half_out     = res_s2.flags.half;
	assign carry_out    = res_s2.flags.carry;

endmodule
